// ----- design/bsf_pkg.sv -----
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and command codes for the bounded stack with filter.
// ----------------------------------------------------------------------------
package bsf_pkg;

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_FILTER = 2'd2;

   localparam int FILL_W = 5;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic               ok;
      logic               is_empty;
      logic [FILL_W-1:0]  fill_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_FILT
   } state_type;

endpackage

// ----- design/bsf_ram.sv -----
// ----------------------------------------------------------------------------
// bsf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bsf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsf_ctrl
// Command sequencer: fill count, push/pop access and the compaction walk
// that drops matching entries.
// ----------------------------------------------------------------------------
module bsf_ctrl #(
   parameter int CAPACITY = 16,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  bsf_pkg::req_type  req_data,
   output logic              req_stall,
   input  logic              out_free,
   output logic              rsp_load,
   output bsf_pkg::rsp_type  rsp_next,
   output logic              mem_we,
   output logic [AW-1:0]     mem_waddr,
   output logic [31:0]       mem_wdata,
   output logic [AW-1:0]     mem_raddr,
   input  logic [31:0]       mem_rdata
);
   import bsf_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rd_ff, rd_in;
   logic [CW-1:0]      wr_ff, wr_in;
   logic               chk_ff, chk_in;
   logic [31:0]        value_ff, value_in;
   logic               accept;
   logic               ok;
   logic [31:0]        popped;
   logic [CW+FILL_W-1:0] count_ext;

   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         chk_ff   <= chk_in;
      end
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      value_ff <= value_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      chk_in    = 1'b0;
      value_in  = value_ff;
      rsp_load  = 1'b0;
      ok        = 1'b0;
      popped    = '0;
      mem_we    = 1'b0;
      mem_waddr = wr_ff[AW-1:0];
      mem_wdata = req_data.value;
      mem_raddr = rd_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_PUSH: begin
                     rsp_load = 1'b1;
                     if (count_ff < CW'(CAPACITY)) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        count_in  = count_ff + 1'b1;
                        ok        = 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff != '0) begin
                        count_in  = count_ff - 1'b1;
                        mem_raddr = count_in[AW-1:0];
                        state_in  = ST_POP;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  CMD_FILTER: begin
                     value_in = req_data.value;
                     rd_in    = '0;
                     wr_in    = '0;
                     state_in = ST_FILT;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_load = 1'b1;
            ok       = 1'b1;
            popped   = mem_rdata;
            state_in = ST_IDLE;
         end
         ST_FILT: begin
            if (rd_ff != count_ff) begin
               mem_raddr = rd_ff[AW-1:0];
               rd_in     = rd_ff + 1'b1;
               chk_in    = 1'b1;
            end
            // keep survivors, packed down toward the bottom
            if (chk_ff && (mem_rdata != value_ff)) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ff[AW-1:0];
               mem_wdata = mem_rdata;
               wr_in     = wr_ff + 1'b1;
            end
            if ((rd_ff == count_ff) && !chk_ff) begin
               count_in = wr_ff;
               rsp_load = 1'b1;
               ok       = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count_ext = {{FILL_W{1'b0}}, count_in};

   always_comb begin
      rsp_next.popped_value = popped;
      rsp_next.ok           = ok;
      rsp_next.is_empty     = (count_in == '0);
      rsp_next.fill_count   = count_ext[FILL_W-1:0];
   end

endmodule

// ----- design/bounded_stack_with_filter.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_filter
// Bounded LIFO of signed 32-bit words with push, pop and filter commands.
// ----------------------------------------------------------------------------
// Push: the result register loads when the request is taken. Pop: the RAM
// read is registered, then the word goes to the result register. Filter: one
// RAM read per entry walked and one write per kept entry.
// One command in flight; the input stalls until its result is registered
// and the result register is free. Synchronous reset empties the stack;
// RAM contents are not cleared.
module bounded_stack_with_filter #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  bsf_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output bsf_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);
   import bsf_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic          out_free;
   logic          rsp_load;
   rsp_type       rsp_next;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [31:0]   mem_rdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   bsf_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_next  (rsp_next),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   bsf_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pop_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.popped_value == '0))
      else $error("failed command returned nonzero word");

   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.cmd == CMD_FILTER) |=> req_stall)
      else $error("input taken during filter walk");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (CAPACITY < 32)) |-> (rsp_data.is_empty == (rsp_data.fill_count == '0)))
      else $error("empty flag disagrees with fill count");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result overwrote an undelivered beat");

endmodule
